// ----- rtl/svma_pkg.sv -----
// shared types and constants for the supply voltage moving average
`timescale 1ns / 1ps
`default_nettype none
package svma_pkg;

  localparam int ACC_W          = 18;
  localparam int SAMPLE_SHIFT   = 6;
  localparam int SAMPLE_W       = ACC_W - SAMPLE_SHIFT;
  localparam int MV_W           = 16;
  localparam int CHARGE_W       = 10;
  localparam int WINDOW_DEPTH_DEF = 128;
  localparam int RECIP_NUM      = 4194304;
  localparam int RECIP_NUM_W    = 23;
  localparam int CHARGE_MAX     = 1000;
  localparam int CHARGE_HALF    = CHARGE_MAX / 2;
  localparam int EMPTY_RESET    = 2500;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_UPDATE,
    S_MEAN,
    S_RECIP,
    S_RECIP_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load_sample;
    logic fill_write;
    logic update;
    logic div_start;
    logic mean_load;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic fill_last;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/svma_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module svma_divider #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quotient_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   rem_diff;
  logic             fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[NUM_W-1]};
    fits      = rem_shift >= {1'b0, den_q};
    rem_diff  = rem_shift - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ----- rtl/svma_datapath.sv -----
// sample window memory, running sum, reciprocal divider and result registers
`timescale 1ns / 1ps
`default_nettype none
module svma_datapath #(
  parameter int WINDOW_DEPTH = svma_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire svma_pkg::cmd_t                  cmd_i,
  output svma_pkg::status_t                    status_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [svma_pkg::MV_W-1:0]       cfg_wdata_i,
  input  wire logic [svma_pkg::ACC_W-1:0]      accumulator_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [svma_pkg::SAMPLE_W-1:0]        window_mean_o,
  output logic [svma_pkg::MV_W-1:0]            supply_millivolts_o,
  output logic [svma_pkg::CHARGE_W-1:0]        charge_tenths_percent_o
);

  localparam int SampleW   = svma_pkg::SAMPLE_W;
  localparam int PtrW      = $clog2(WINDOW_DEPTH);
  localparam int SumW      = SampleW + PtrW;
  localparam int NumW      = svma_pkg::RECIP_NUM_W;
  localparam int DenW      = SampleW;
  localparam int MvW       = svma_pkg::MV_W;
  localparam int ChW       = svma_pkg::CHARGE_W;
  localparam int MeanShift = SumW + PtrW;
  localparam int MulW      = SumW + 1;
  localparam int ProdW     = SumW + MulW;
  // rounded-up reciprocal of the depth, exact floor quotient for any sum below 2**SumW
  localparam longint unsigned MeanMul =
    ((64'd1 << MeanShift) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);

  logic [SampleW-1:0] mem [WINDOW_DEPTH];
  logic [SampleW-1:0] rd_q;
  logic [SampleW-1:0] sample_q;
  logic [PtrW-1:0]    wptr_q;
  logic [SumW-1:0]    sum_q;
  logic               primed_q;
  logic [MvW-1:0]     empty_q;
  logic [SampleW-1:0] mean_q;
  logic               out_valid_q;
  logic [SampleW-1:0] out_mean_q;
  logic [MvW-1:0]     out_mv_q;
  logic [ChW-1:0]     out_charge_q;

  logic               mem_we;
  logic               wptr_last;
  logic [ProdW-1:0]   mean_prod;
  logic [NumW-1:0]    div_num;
  logic [DenW-1:0]    div_den;
  logic               div_busy;
  logic [NumW-1:0]    div_quo;
  logic               mv_sat;
  logic [MvW-1:0]     mv;
  logic [MvW:0]       mv_diff;
  logic [ChW-1:0]     charge;

  assign mem_we    = cmd_i.fill_write | cmd_i.update;
  assign wptr_last = wptr_q == PtrW'(WINDOW_DEPTH - 1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wptr_q] <= sample_q;
    end
    rd_q <= mem[wptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= accumulator_value_i[svma_pkg::ACC_W-1:svma_pkg::SAMPLE_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      sum_q    <= '0;
      primed_q <= 1'b0;
      empty_q  <= MvW'(svma_pkg::EMPTY_RESET);
    end else begin
      if (cfg_we_i) begin
        empty_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        wptr_q <= wptr_last ? '0 : wptr_q + PtrW'(1);
      end
      // the fill sweep ends with the pointer back at zero
      if (cmd_i.fill_write && wptr_last) begin
        sum_q    <= SumW'(sample_q) * SumW'(WINDOW_DEPTH);
        primed_q <= 1'b1;
      end else if (cmd_i.update) begin
        sum_q <= sum_q - SumW'(rd_q) + SumW'(sample_q);
      end
    end
  end

  // a plain shift when the depth is a power of two
  assign mean_prod = ProdW'(sum_q) * ProdW'(MeanMul);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_load) begin
      mean_q <= mean_prod[MeanShift +: SampleW];
    end
  end

  assign div_num = NumW'(svma_pkg::RECIP_NUM);
  assign div_den = mean_q;

  svma_divider #(
    .NUM_W (NumW),
    .DEN_W (DenW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_comb begin
    mv_sat  = (mean_q == '0) || (|div_quo[NumW-1:MvW]);
    mv      = mv_sat ? {MvW{1'b1}} : div_quo[MvW-1:0];
    mv_diff = {1'b0, mv} - {1'b0, empty_q};
    if (mv <= empty_q) begin
      charge = '0;
    end else if (mv_diff[MvW-1:0] >= MvW'(svma_pkg::CHARGE_HALF)) begin
      charge = ChW'(svma_pkg::CHARGE_MAX);
    end else begin
      // difference below half of full scale, doubling stays in range
      charge = {mv_diff[ChW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_mean_q   <= mean_q;
      out_mv_q     <= mv;
      out_charge_q <= charge;
    end
  end

  always_comb begin
    status_o.primed    = primed_q;
    status_o.fill_last = wptr_last;
    status_o.div_busy  = div_busy;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o             = out_valid_q;
  assign window_mean_o           = out_mean_q;
  assign supply_millivolts_o     = out_mv_q;
  assign charge_tenths_percent_o = out_charge_q;

endmodule
`default_nettype wire

// ----- rtl/svma_ctrl.sv -----
// sequencing state machine for one transaction at a time
`timescale 1ns / 1ps
`default_nettype none
module svma_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire svma_pkg::status_t status_i,
  output svma_pkg::cmd_t         cmd_o
);

  svma_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svma_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      svma_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.primed ? svma_pkg::S_READ : svma_pkg::S_FILL;
        end
      end
      svma_pkg::S_FILL: begin
        if (status_i.fill_last) begin
          state_d = svma_pkg::S_MEAN;
        end
      end
      svma_pkg::S_READ:   state_d = svma_pkg::S_UPDATE;
      svma_pkg::S_UPDATE: state_d = svma_pkg::S_MEAN;
      svma_pkg::S_MEAN:   state_d = svma_pkg::S_RECIP;
      svma_pkg::S_RECIP:  state_d = svma_pkg::S_RECIP_WAIT;
      svma_pkg::S_RECIP_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = svma_pkg::S_DONE;
        end
      end
      svma_pkg::S_DONE: begin
        if (status_i.out_free) begin
          state_d = svma_pkg::S_IDLE;
        end
      end
      default: state_d = svma_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      svma_pkg::S_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.load_sample = in_valid_i;
      end
      svma_pkg::S_FILL:   cmd_o.fill_write = 1'b1;
      svma_pkg::S_READ:   ;
      svma_pkg::S_UPDATE: cmd_o.update = 1'b1;
      svma_pkg::S_MEAN:   cmd_o.mean_load = 1'b1;
      svma_pkg::S_RECIP:  cmd_o.div_start = 1'b1;
      svma_pkg::S_RECIP_WAIT: ;
      svma_pkg::S_DONE: begin
        cmd_o.result_load = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/supply_voltage_moving_average_top.sv -----
// top level of the supply voltage moving average
//
// Each accepted transaction takes one 18-bit accumulator reading, keeps bits 17:6 as a sample
// and returns the mean of the last WINDOW_DEPTH samples, the supply in millivolts
// (4194304 / mean, saturated to 65535) and a charge figure in tenths of a percent. One
// transaction is worked at a time. The mean is registered from the running sum times a
// rounded-up reciprocal of the depth (a plain shift at a power-of-two depth); the reciprocal
// 4194304 / mean comes from an iterative divider, one quotient bit per cycle, which sets the
// pace. The very first transaction after reset sweeps the sample into every memory entry,
// one per cycle, in place of the read and update states. A finished result waits in an
// output register while the next transaction is taken; the following result then waits, and
// input stays blocked, until that register is free. The empty level empty_q resets to 2500;
// the user must write it through cfg_we_i / cfg_wdata_i only while the block is idle, which
// the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module supply_voltage_moving_average_top #(
  parameter int WINDOW_DEPTH = svma_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [svma_pkg::MV_W-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [svma_pkg::ACC_W-1:0]      accumulator_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [svma_pkg::SAMPLE_W-1:0]        window_mean_o,
  output logic [svma_pkg::MV_W-1:0]            supply_millivolts_o,
  output logic [svma_pkg::CHARGE_W-1:0]        charge_tenths_percent_o
);

  svma_pkg::cmd_t    cmd;
  svma_pkg::status_t status;

  svma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  svma_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .status_o                (status),
    .cfg_we_i                (cfg_we_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .accumulator_value_i     (accumulator_value_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .window_mean_o           (window_mean_o),
    .supply_millivolts_o     (supply_millivolts_o),
    .charge_tenths_percent_o (charge_tenths_percent_o)
  );

endmodule
`default_nettype wire

// ----- test/tb_supply_voltage_moving_average_top.sv -----
// testbench for the supply voltage moving average top level
`timescale 1ns / 1ps
module tb_supply_voltage_moving_average_top;
  import svma_pkg::*;

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);
  localparam int MV_MAX = (1 << MV_W) - 1;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int NUM_PHASES = 8;
  localparam int HOLD_OFF_LEN = 400;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 64;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [MV_W-1:0]     mv;
    logic [CHARGE_W-1:0] charge;
  } supply_reading_t;

  typedef enum int {
    RUN_ZERO, RUN_TINY, RUN_AT_64, RUN_AT_65, RUN_FULL_SCALE, RUN_NOMINAL, RUN_NOISE
  } level_run_e;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  class supply_scoreboard;
    logic [SAMPLE_W-1:0] window_q[DEPTH];
    logic [SUM_W-1:0]    window_sum;
    int unsigned         oldest;
    bit                  primed;
    logic [MV_W-1:0]     empty_mv;
    supply_reading_t     expected_readings[$];
    int unsigned         mismatches;

    function new();
      empty_mv = EMPTY_RESET;
      primed = 1'b0;
      oldest = 0;
      window_sum = '0;
      mismatches = 0;
    endfunction

    function void set_empty_level(logic [MV_W-1:0] level);
      empty_mv = level;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // accepted input transaction: update the window and queue the reading it yields
    function void note_sample(logic [ACC_W-1:0] acc);
      logic [SAMPLE_W-1:0] smp;
      logic [SAMPLE_W-1:0] mean;
      int unsigned         quot;
      int                  diff;
      supply_reading_t     r;
      smp = acc[ACC_W-1:SAMPLE_SHIFT];
      if (!primed) begin
        // first sample after reset fills the whole window
        foreach (window_q[i]) window_q[i] = smp;
        window_sum = SUM_W'(smp * DEPTH);
        oldest = 0;
        primed = 1'b1;
      end else begin
        window_sum = window_sum - window_q[oldest] + smp;
        window_q[oldest] = smp;
        oldest = (oldest + 1) % DEPTH;
      end
      mean = SAMPLE_W'(window_sum / DEPTH);
      if (mean == 0) quot = MV_MAX;
      else quot = RECIP_NUM / mean;
      if (quot > MV_MAX) quot = MV_MAX;
      diff = (int'(quot) - int'(empty_mv)) * 2;
      if (diff < 0) diff = 0;
      if (diff > CHARGE_MAX) diff = CHARGE_MAX;
      r.mean = mean;
      r.mv = MV_W'(quot);
      r.charge = CHARGE_W'(diff);
      expected_readings.push_back(r);
    endfunction

    task check_reading(logic [SAMPLE_W-1:0] mean, logic [MV_W-1:0] mv,
                       logic [CHARGE_W-1:0] charge);
      supply_reading_t want;
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("result with no transaction pending (mean %0d)", mean));
      end else begin
        want = expected_readings.pop_front();
        if (mean !== want.mean)
          report_mismatch($sformatf("window_mean got %0d expected %0d", mean, want.mean));
        if (mv !== want.mv)
          report_mismatch($sformatf("supply_millivolts got %0d expected %0d", mv, want.mv));
        if (charge !== want.charge)
          report_mismatch($sformatf("charge_tenths_percent got %0d expected %0d",
                                    charge, want.charge));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [MV_W-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ACC_W-1:0]    accumulator_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0] window_mean_o;
  logic [MV_W-1:0]     supply_millivolts_o;
  logic [CHARGE_W-1:0] charge_tenths_percent_o;

  supply_scoreboard books = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  level_run_e    run_kind = RUN_ZERO;
  int            run_left = 0;
  int            run_level = 0;
  int            run_jitter = 0;
  int unsigned   run_count = 0;

  supply_voltage_moving_average_top dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .accumulator_value_i     (accumulator_value_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .window_mean_o           (window_mean_o),
    .supply_millivolts_o     (supply_millivolts_o),
    .charge_tenths_percent_o (charge_tenths_percent_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL supply_voltage_moving_average_top");
    $finish;
  end

  // result side: check each accepted transaction, then pick the next ready
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        books.check_reading(window_mean_o, supply_millivolts_o, charge_tenths_percent_o);
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // mostly slow level runs so the window mean sweeps through its whole range
  function automatic logic [ACC_W-1:0] next_accumulator();
    int lvl;
    if (run_left == 0) begin
      run_kind = level_run_e'(run_count % 7);
      run_count++;
      run_left = $urandom_range(200, 60);
      run_jitter = ($urandom_range(1) == 1) ? 3 : 0;
      case (run_kind)
        RUN_ZERO:       run_level = 0;
        RUN_TINY:       run_level = $urandom_range(63, 1);
        RUN_AT_64:      run_level = 64;
        RUN_AT_65:      run_level = 65;
        RUN_FULL_SCALE: run_level = (1 << SAMPLE_W) - 1;
        RUN_NOMINAL:    run_level = $urandom_range(2000, 600);
        default:        run_level = 0;
      endcase
    end
    run_left--;
    if (run_kind == RUN_NOISE) return ACC_W'($urandom);
    lvl = run_level + int'($urandom_range(2 * run_jitter)) - run_jitter;
    if (lvl < 0) lvl = 0;
    if (lvl > (1 << SAMPLE_W) - 1) lvl = (1 << SAMPLE_W) - 1;
    return {SAMPLE_W'(lvl), SAMPLE_SHIFT'($urandom)};
  endfunction

  // called at a clock edge; returns at the edge where the transaction is taken
  task automatic send_reading(input logic [ACC_W-1:0] acc);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accumulator_value_i <= acc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    books.note_sample(acc);
  endtask

  task automatic wait_drained();
    while (books.pending() != 0) @(posedge clk_i);
  endtask

  // only called with the block idle and no transaction offered
  task automatic write_empty_level(input logic [MV_W-1:0] level);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= level;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    books.set_empty_level(level);
  endtask

  task automatic settle_and_write(input logic [MV_W-1:0] level);
    in_valid_i <= 1'b0;
    wait_drained();
    write_empty_level(level);
  endtask

  initial begin
    logic [MV_W-1:0] phase_levels[NUM_PHASES];
    phase_levels = '{16'(EMPTY_RESET), 16'd0, 16'hFFFF, 16'd3000,
                     16'($urandom_range(4500, 2000)), 16'(EMPTY_RESET),
                     16'($urandom), 16'd4000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill at full scale, then walk the charge figure around its edges
    send_reading({12'hFFF, 6'h15});
    send_reading({ACC_W{1'b1}});
    settle_and_write(16'd1024);
    send_reading({ACC_W{1'b1}});
    settle_and_write(16'd1023);
    send_reading({12'hFFF, 6'h00});
    settle_and_write(16'd524);
    send_reading({12'hFFF, 6'h2A});
    settle_and_write(16'd523);
    send_reading({12'hFFF, 6'h3F});
    settle_and_write(16'd0);
    send_reading({ACC_W{1'b1}});
    settle_and_write(16'hFFFF);
    send_reading({ACC_W{1'b1}});
    settle_and_write(16'(EMPTY_RESET));
    send_reading('0);
    send_reading(18'h2AAAA);
    send_reading(18'h15555);
    send_reading(18'h0003F);
    send_reading(18'h00040);
    send_reading(18'h00FFF);
    send_reading(18'h3F000);
    send_reading({ACC_W{1'b1}});

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) settle_and_write(phase_levels[p]);
      case (idle_mode_e'(p % 4))
        IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SENDER:   begin send_idle_pct = 51; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default:       begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      // long receiver hold-off so the output register fills and input backs up
      if (p == 4) hold_off_cycles <= HOLD_OFF_LEN;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_reading(next_accumulator());
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (books.pending() != 0)
      books.report_mismatch($sformatf("%0d readings never arrived", books.pending()));
    if (books.mismatches == 0) begin
      $display("PASS supply_voltage_moving_average_top");
    end else begin
      $display("FAIL supply_voltage_moving_average_top");
    end
    $finish;
  end

endmodule
